// ===== src/vdcps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vdcps_pkg;

  localparam logic [63:0] GOLDEN_C = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIXER_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIXER_B  = 64'h94d049bb133111eb;

  // gray = GRAY_BASE + floor(GRAY_BASE*r/255), with GRAY_BASE = 115*255 + 166
  localparam logic [16:0] GRAY_BASE = 17'd29491;
  localparam logic [16:0] GRAY_QUOT = 17'd115;
  localparam logic [16:0] GRAY_REM  = 17'd166;

  localparam int unsigned SLOT_W = 12;

  // last micro-op index of one hash round
  localparam logic [4:0] HASH_LAST = 5'd25;

  typedef logic [2:0] act_t;
  localparam act_t ACT_NONE    = 3'd0;
  localparam act_t ACT_DUP     = 3'd1;
  localparam act_t ACT_APPEND  = 3'd2;
  localparam act_t ACT_REPLACE = 3'd3;
  localparam act_t ACT_NOSEL   = 3'd4;
  localparam act_t ACT_NOSLOT  = 3'd5;

  typedef enum logic [3:0] {
    U_NOP, U_HINIT, U_KLOAD, U_HLOAD, U_HXOR, U_HSET,
    U_XS30, U_XS27, U_XS31, U_P0, U_P1, U_P2, U_P3
  } ucode_t;

  typedef enum logic [1:0] {C_GOLD, C_MIXA, C_MIXB} csel_t;

  typedef struct packed {
    ucode_t code;
    csel_t  csel;
  } uop_t;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       div_start;
    logic       div_mod;
    logic [1:0] axis;
    logic       key_take;
    logic       scan_rst;
    logic       scan_inc;
    logic       seen_inc;
    logic       append;
    logic       replace;
    logic       set_full;
    logic       emit;
    act_t       action;
    uop_t       uop;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic match;
    logic scan_last;
    logic used_zero;
    logic cap_zero;
    logic has_free;
    logic sel;
    logic op;
    logic enable;
  } stat_t;

  // one splitmix scramble: xorshift, multiply by A, xorshift, multiply by B, xorshift
  function automatic uop_t scr_uop(logic [3:0] s);
    uop_t u;
    u.csel = (s < 4'd5) ? C_MIXA : C_MIXB;
    unique case (s) inside
      4'd0:        u.code = U_XS30;
      4'd1, 4'd6:  u.code = U_P0;
      4'd2, 4'd7:  u.code = U_P1;
      4'd3, 4'd8:  u.code = U_P2;
      4'd4, 4'd9:  u.code = U_P3;
      4'd5:        u.code = U_XS27;
      4'd10:       u.code = U_XS31;
      default:     u.code = U_NOP;
    endcase
    return u;
  endfunction

  // one round per key word: h ^= scr(k + c); h = scr(h)
  function automatic uop_t hash_uop(logic [4:0] step, logic [1:0] seg);
    uop_t u;
    u.code = U_NOP;
    u.csel = C_GOLD;
    if (step == 5'd0) begin
      u.code = U_KLOAD;
      u.csel = csel_t'(seg);
    end else if (step <= 5'd11) begin
      u = scr_uop(4'(step - 5'd1));
    end else if (step == 5'd12) begin
      u.code = U_HXOR;
    end else if (step == 5'd13) begin
      u.code = U_HLOAD;
    end else if (step <= 5'd24) begin
      u = scr_uop(4'(step - 5'd14));
    end else begin
      u.code = U_HSET;
    end
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== src/vdcps_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface vdcps_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [7:0]         reflect;
  modport source(output valid, op, pos_x, pos_y, pos_z, reflect, input ready);
  modport sink(input valid, op, pos_x, pos_y, pos_z, reflect, output ready);
endinterface

interface vdcps_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [11:0]        slot;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [15:0]        gray;
  logic               limit_reached;
  modport source(output valid, action, slot, out_x, out_y, out_z, gray, limit_reached,
                 input ready);
  modport sink(input valid, action, slot, out_x, out_y, out_z, gray, limit_reached,
               output ready);
endinterface
`default_nettype wire

// ===== src/voxel_dedup_capped_point_store_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Voxel-deduplicating point store. Each insert transaction floor-divides its three
// millimetre coordinates by voxel_size_mm into a voxel key, searches the held keys
// and reports duplicate, appended, replaced (reservoir choice by a splitmix64 hash
// modulo the count of voxels seen), not selected, or no slots. op=1 clears the store;
// any configuration write that changes a register value clears it too. One
// transaction is handled at a time: an insert runs three key divisions, a scan of
// the held keys and, when the store is full, the hash and its modulo. The shared
// serial divider serves the three key divisions and the modulo; the hash runs on one
// 32x32 multiplier. A clear or a disabled insert goes straight to its result; a
// duplicate ends the scan at its match. The next transaction is taken while the last
// result still waits in the output register. The key memory needs no clearing pass.
module voxel_dedup_capped_point_store_core import vdcps_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  vdcps_in_if.sink         in_ch,
  vdcps_out_if.source      out_ch
);

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_MAXPTS = 2'd1;
  localparam logic [1:0] REG_VOXEL  = 2'd2;

  logic        store_enable;
  logic [12:0] max_points;
  logic [15:0] voxel_size_mm;
  logic        wr;
  logic [1:0]  ridx;
  logic        cfg_clear;
  cmd_t        cmd;
  stat_t       st;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[3:2];

  // a write that changes a value wipes the store
  always_comb begin
    cfg_clear = 1'b0;
    if (wr) begin
      unique case (ridx)
        REG_ENABLE: cfg_clear = (pwdata[0] != store_enable);
        REG_MAXPTS: cfg_clear = (pwdata[12:0] != max_points);
        REG_VOXEL:  cfg_clear = (pwdata[15:0] != voxel_size_mm);
        default:    cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_enable  <= 1'b1;
      max_points    <= 13'd4096;
      voxel_size_mm <= 16'd100;
    end else if (wr) begin
      unique case (ridx)
        REG_ENABLE: store_enable  <= pwdata[0];
        REG_MAXPTS: max_points    <= pwdata[12:0];
        REG_VOXEL:  voxel_size_mm <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ENABLE: prdata = {31'd0, store_enable};
      REG_MAXPTS: prdata = {19'd0, max_points};
      REG_VOXEL:  prdata = {16'd0, voxel_size_mm};
      default:    prdata = '0;
    endcase
  end

  // sequencer: divisions, key scan, hash, placement, result handoff
  vdcps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // key memory, counters, divider, hash engine and result register
  vdcps_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_clear     (cfg_clear),
    .store_enable  (store_enable),
    .max_points    (max_points),
    .voxel_size_mm (voxel_size_mm),
    .in_op         (in_ch.op),
    .in_x          (in_ch.pos_x),
    .in_y          (in_ch.pos_y),
    .in_z          (in_ch.pos_z),
    .in_refl       (in_ch.reflect),
    .o_action      (out_ch.action),
    .o_slot        (out_ch.slot),
    .o_x           (out_ch.out_x),
    .o_y           (out_ch.out_y),
    .o_z           (out_ch.out_z),
    .o_gray        (out_ch.gray),
    .o_limit       (out_ch.limit_reached)
  );

endmodule
`default_nettype wire

// ===== src/vdcps_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vdcps_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [63:0]      quot,
  output logic [31:0]      rem
);

  logic [6:0]  cnt;
  logic [31:0] dvs;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem, quot[63]};
  assign diff  = trial - {1'b0, dvs};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt  <= 7'd64;
        quot <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (cnt != 7'd0) begin
        cnt  <= cnt - 7'd1;
        done <= (cnt == 7'd1);
        if (!diff[32]) begin
          rem  <= diff[31:0];
          quot <= {quot[62:0], 1'b1};
        end else begin
          rem  <= trial[31:0];
          quot <= {quot[62:0], 1'b0};
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/vdcps_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vdcps_dp import vdcps_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output stat_t                   st,
  input  wire logic               cfg_clear,
  input  wire logic               store_enable,
  input  wire logic [12:0]        max_points,
  input  wire logic [15:0]        voxel_size_mm,
  input  wire logic               in_op,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic signed [31:0] in_z,
  input  wire logic [7:0]         in_refl,
  output act_t                    o_action,
  output logic [SLOT_W-1:0]       o_slot,
  output logic signed [31:0]      o_x,
  output logic signed [31:0]      o_y,
  output logic signed [31:0]      o_z,
  output logic [15:0]             o_gray,
  output logic                    o_limit
);

  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

  logic               op_q;
  logic signed [31:0] px, py, pz;
  logic [7:0]         refl;
  logic [31:0]        k0, k1, k2;

  logic [CW-1:0] used;
  logic [AW-1:0] cursor;
  logic [31:0]   seen;
  logic          full;
  logic [AW-1:0] idx;
  logic [AW-1:0] slot_q;

  logic [95:0] mem [MAX_SLOTS];
  logic [95:0] rdata;
  logic        wr_en;
  logic [AW-1:0] wr_addr;

  logic [CW-1:0] cap;
  logic [15:0]   vs_eff;
  logic [31:0]   coord;
  logic          neg;
  logic [31:0]   mag;
  logic [63:0]   quot;
  logic [31:0]   rem;
  logic          div_done;
  logic [31:0]   fkey;
  logic [AW-1:0] cur_eff;

  logic [63:0] hv, hh, acc, prod;
  logic [63:0] cval;
  logic [31:0] ksel;
  logic [31:0] ma, mb;
  logic [63:0] mp;

  logic [16:0] gx, gx1, gfrac, gsum;
  logic        stored;

  always_comb begin
    if ({19'd0, max_points} > MAX_SLOTS) cap = CW'(MAX_SLOTS);
    else cap = CW'(max_points);
  end

  assign vs_eff = (voxel_size_mm == 16'd0) ? 16'd1 : voxel_size_mm;

  always_comb begin
    case (cmd.axis)
      2'd0:    coord = px;
      2'd1:    coord = py;
      default: coord = pz;
    endcase
  end

  assign neg = coord[31];
  assign mag = neg ? (32'd0 - coord) : coord;

  vdcps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_mod ? hh : {32'd0, mag}),
    .divisor  (cmd.div_mod ? seen : {16'd0, vs_eff}),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // floor toward minus infinity: -q when exact, ~q = -q-1 otherwise
  always_comb begin
    if (!neg) fkey = quot[31:0];
    else if (rem == 32'd0) fkey = 32'd0 - quot[31:0];
    else fkey = ~quot[31:0];
  end

  assign cur_eff = (CW'(cursor) >= cap) ? '0 : cursor;

  // input capture and keys
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= in_op;
      px   <= in_x;
      py   <= in_y;
      pz   <= in_z;
      refl <= in_refl;
    end
    if (cmd.key_take) begin
      case (cmd.axis)
        2'd0:    k0 <= fkey;
        2'd1:    k1 <= fkey;
        default: k2 <= fkey;
      endcase
    end
  end

  // store bookkeeping
  always_ff @(posedge clk) begin
    if (rst || cfg_clear || cmd.clear) begin
      used   <= '0;
      cursor <= '0;
      seen   <= '0;
      full   <= 1'b0;
    end else begin
      if (cmd.seen_inc && seen != 32'hFFFF_FFFF) seen <= seen + 32'd1;
      if (cmd.set_full) full <= 1'b1;
      if (cmd.append) begin
        used   <= used + CW'(1);
        slot_q <= used[AW-1:0];
      end
      if (cmd.replace) begin
        slot_q <= cur_eff;
        cursor <= (CW'(cur_eff) + CW'(1) == cap) ? '0 : cur_eff + AW'(1);
      end
    end
    if (cmd.scan_rst) idx <= '0;
    else if (cmd.scan_inc) idx <= idx + AW'(1);
  end

  assign wr_en   = cmd.append | cmd.replace;
  assign wr_addr = cmd.append ? used[AW-1:0] : cur_eff;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {k2, k1, k0};
    rdata <= mem[idx];
  end

  // hash engine: 64-bit products from three 32x32 partial products
  always_comb begin
    case (cmd.uop.csel)
      C_GOLD:  begin cval = GOLDEN_C; ksel = k0; end
      C_MIXA:  begin cval = MIXER_A;  ksel = k1; end
      default: begin cval = MIXER_B;  ksel = k2; end
    endcase
    case (cmd.uop.code)
      U_P1:    begin ma = hv[31:0];  mb = cval[63:32]; end
      U_P2:    begin ma = hv[63:32]; mb = cval[31:0];  end
      default: begin ma = hv[31:0];  mb = cval[31:0];  end
    endcase
  end

  assign mp = 64'(ma) * 64'(mb);

  always_ff @(posedge clk) begin
    case (cmd.uop.code)
      U_HINIT: hh <= GOLDEN_C;
      U_KLOAD: hv <= {{32{ksel[31]}}, ksel} + cval;
      U_HLOAD: hv <= hh;
      U_HXOR:  hh <= hh ^ hv;
      U_HSET:  hh <= hv;
      U_XS30:  hv <= hv ^ (hv >> 30);
      U_XS27:  hv <= hv ^ (hv >> 27);
      U_XS31:  hv <= hv ^ (hv >> 31);
      U_P0:    prod <= mp;
      U_P1:    begin acc <= prod; prod <= mp; end
      U_P2:    begin acc <= acc + {prod[31:0], 32'd0}; prod <= mp; end
      U_P3:    hv <= acc + {prod[31:0], 32'd0};
      default: ;
    endcase
  end

  // floor(166*r/255) by the divide-by-255 identity, exact below 65535
  assign gx    = 17'(refl) * GRAY_REM;
  assign gx1   = gx + 17'd1;
  assign gfrac = (gx1 + (gx1 >> 8)) >> 8;
  assign gsum  = GRAY_BASE + 17'(refl) * GRAY_QUOT + gfrac;

  assign stored = (cmd.action == ACT_APPEND) || (cmd.action == ACT_REPLACE);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_action <= cmd.action;
      o_limit  <= full;
      o_slot   <= stored ? SLOT_W'(slot_q) : '0;
      o_x      <= stored ? px : '0;
      o_y      <= stored ? py : '0;
      o_z      <= stored ? pz : '0;
      o_gray   <= stored ? gsum[15:0] : '0;
    end
  end

  always_comb begin
    st.div_done  = div_done;
    st.match     = (rdata == {k2, k1, k0});
    st.scan_last = (CW'(idx) + CW'(1) == used);
    st.used_zero = (used == '0);
    st.cap_zero  = (cap == '0);
    st.has_free  = (used < cap);
    st.sel       = (rem < 32'(cap));
    st.op        = op_q;
    st.enable    = store_enable;
  end

endmodule
`default_nettype wire

// ===== src/vdcps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vdcps_ctrl import vdcps_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t st,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_DIV_GO, S_DIV_WAIT, S_SCAN_CHK, S_SCAN_RD, S_SCAN_CMP,
    S_NEW, S_HINIT, S_HASH, S_MOD_GO, S_MOD_WAIT, S_PLACE, S_EMIT
  } state_t;

  state_t     state;
  logic [1:0] axis;
  logic [4:0] step;
  logic [1:0] seg;
  act_t       act;
  logic       emit_ok;

  assign in_ready = (state == S_IDLE);
  assign emit_ok  = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.axis   = axis;
    cmd.action = act;
    cmd.uop    = '{code: U_NOP, csel: C_GOLD};
    unique case (state)
      S_IDLE:     cmd.load = in_valid;
      S_DECIDE:   cmd.clear = st.op;
      S_DIV_GO:   cmd.div_start = 1'b1;
      S_DIV_WAIT: cmd.key_take = st.div_done;
      S_SCAN_CHK: cmd.scan_rst = 1'b1;
      S_SCAN_RD:  ;
      S_SCAN_CMP: cmd.scan_inc = !st.match && !st.scan_last;
      S_NEW: begin
        cmd.seen_inc = 1'b1;
        cmd.append   = !st.cap_zero && st.has_free;
        cmd.set_full = !st.cap_zero && !st.has_free;
      end
      S_HINIT:    cmd.uop.code = U_HINIT;
      S_HASH:     cmd.uop = hash_uop(step, seg);
      S_MOD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_mod   = 1'b1;
      end
      S_MOD_WAIT: cmd.div_mod = 1'b1;
      S_PLACE:    cmd.replace = st.sel;
      S_EMIT:     cmd.emit = emit_ok;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      axis      <= '0;
      step      <= '0;
      seg       <= '0;
      act       <= ACT_NONE;
    end else begin
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_DECIDE;
        S_DECIDE: begin
          act  <= ACT_NONE;
          axis <= '0;
          if (st.op || !st.enable) state <= S_EMIT;
          else state <= S_DIV_GO;
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (st.div_done) begin
            if (axis == 2'd2) state <= S_SCAN_CHK;
            else begin
              axis  <= axis + 2'd1;
              state <= S_DIV_GO;
            end
          end
        end
        S_SCAN_CHK: state <= st.used_zero ? S_NEW : S_SCAN_RD;
        S_SCAN_RD:  state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (st.match) begin
            act   <= ACT_DUP;
            state <= S_EMIT;
          end else if (st.scan_last) state <= S_NEW;
          else state <= S_SCAN_RD;
        end
        S_NEW: begin
          if (st.cap_zero) begin
            act   <= ACT_NOSLOT;
            state <= S_EMIT;
          end else if (st.has_free) begin
            act   <= ACT_APPEND;
            state <= S_EMIT;
          end else state <= S_HINIT;
        end
        S_HINIT: begin
          step  <= '0;
          seg   <= '0;
          state <= S_HASH;
        end
        S_HASH: begin
          if (step == HASH_LAST) begin
            step <= '0;
            if (seg == 2'd2) state <= S_MOD_GO;
            else seg <= seg + 2'd1;
          end else step <= step + 5'd1;
        end
        S_MOD_GO:   state <= S_MOD_WAIT;
        S_MOD_WAIT: if (st.div_done) state <= S_PLACE;
        S_PLACE: begin
          act   <= st.sel ? ACT_REPLACE : ACT_NOSEL;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.emit)
    else $error("result overwritten before taken");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> (st.has_free && !st.cap_zero))
    else $error("append without a free slot");

  a_replace_full: assert property (@(posedge clk) disable iff (rst)
    cmd.replace |-> (st.sel && !st.has_free))
    else $error("replace while slots remain or not selected");

  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DECIDE))
    else $error("accepted transaction not decoded");

endmodule
`default_nettype wire

// ===== dv/vdcps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vdcps_checker import vdcps_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  vdcps_in_if              in_ch,
  vdcps_out_if             out_ch,
  output int               fail_count,
  output int               pending,
  output int               n_results,
  output int               n_replaced
);

  typedef struct packed {
    act_t        action;
    logic [11:0] slot;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [15:0] gray;
    logic        lim;
  } vertex_res_t;

  vertex_res_t vertex_q[$];

  logic [31:0] held_key[4096][3];
  int unsigned fill_count;
  int unsigned cursor;
  logic [31:0] voxels_seen;
  logic        was_full;
  logic        enable_reg;
  logic [12:0] cap_reg;
  logic [15:0] size_reg;

  function automatic logic [63:0] mix64(logic [63:0] v);
    v = v ^ (v >> 30);
    v = v * MIXER_A;
    v = v ^ (v >> 27);
    v = v * MIXER_B;
    v = v ^ (v >> 31);
    return v;
  endfunction

  function automatic logic [63:0] voxel_hash(logic [31:0] k0, logic [31:0] k1,
                                             logic [31:0] k2);
    logic [63:0] h;
    h = GOLDEN_C;
    h = h ^ mix64({{32{k0[31]}}, k0} + GOLDEN_C);
    h = mix64(h);
    h = h ^ mix64({{32{k1[31]}}, k1} + MIXER_A);
    h = mix64(h);
    h = h ^ mix64({{32{k2[31]}}, k2} + MIXER_B);
    return mix64(h);
  endfunction

  function automatic logic [31:0] floor_div(logic signed [31:0] x, longint d);
    longint xl;
    longint q;
    xl = x;
    q = xl / d;
    if ((xl % d) != 0 && xl < 0) q = q - 1;
    return q[31:0];
  endfunction

  task automatic wipe_store();
    fill_count  = 0;
    cursor      = 0;
    voxels_seen = 0;
    was_full    = 1'b0;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      2'd0: if (enable_reg != val[0]) begin
        enable_reg = val[0];
        wipe_store();
      end
      2'd1: if (cap_reg != val[12:0]) begin
        cap_reg = val[12:0];
        wipe_store();
      end
      2'd2: if (size_reg != val[15:0]) begin
        size_reg = val[15:0];
        wipe_store();
      end
      default: ;
    endcase
  endtask

  task automatic predict_point();
    vertex_res_t r;
    logic [31:0] k[3];
    longint      d;
    int unsigned cap;
    bit          hit;
    logic [63:0] h;
    r = '0;
    r.action = ACT_NONE;
    if (in_ch.op) begin
      wipe_store();
    end else if (enable_reg) begin
      d = (size_reg == 0) ? 1 : size_reg;
      k[0] = floor_div(in_ch.pos_x, d);
      k[1] = floor_div(in_ch.pos_y, d);
      k[2] = floor_div(in_ch.pos_z, d);
      cap = (cap_reg > 4096) ? 4096 : cap_reg;
      hit = 0;
      for (int i = 0; i < fill_count; i++)
        if (held_key[i][0] == k[0] && held_key[i][1] == k[1] && held_key[i][2] == k[2])
          hit = 1;
      if (hit) begin
        r.action = ACT_DUP;
      end else begin
        if (voxels_seen != 32'hFFFF_FFFF) voxels_seen = voxels_seen + 1;
        if (cap == 0) begin
          r.action = ACT_NOSLOT;
        end else if (fill_count < cap) begin
          r.slot = fill_count[11:0];
          held_key[fill_count] = k;
          fill_count = fill_count + 1;
          r.action = ACT_APPEND;
        end else begin
          was_full = 1'b1;
          h = voxel_hash(k[0], k[1], k[2]);
          if ((h % {32'd0, voxels_seen}) < cap) begin
            if (cursor >= cap) cursor = 0;
            r.slot = cursor[11:0];
            held_key[cursor] = k;
            cursor = (cursor + 1) % cap;
            r.action = ACT_REPLACE;
          end else begin
            r.action = ACT_NOSEL;
          end
        end
      end
      // stored vertex fields are reported only when a slot was written
      if (r.action == ACT_APPEND || r.action == ACT_REPLACE) begin
        r.vx = in_ch.pos_x;
        r.vy = in_ch.pos_y;
        r.vz = in_ch.pos_z;
        r.gray = 16'(29491 + (29491 * int'(in_ch.reflect)) / 255);
      end
    end
    r.lim = was_full;
    vertex_q.insert(vertex_q.size(), r);
  endtask

  always @(posedge clk) begin
    vertex_res_t got;
    vertex_res_t want;
    if (rst) begin
      vertex_q.delete();
      wipe_store();
      enable_reg = 1'b1;
      cap_reg    = 13'd4096;
      size_reg   = 16'd100;
      fail_count = 0;
      n_results  = 0;
      n_replaced = 0;
    end else begin
      if (psel && penable && pwrite && pready) write_reg(paddr[3:2], pwdata);
      if (in_ch.valid && in_ch.ready) predict_point();
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.action, out_ch.slot, out_ch.out_x, out_ch.out_y, out_ch.out_z,
                out_ch.gray, out_ch.limit_reached};
        n_results = n_results + 1;
        if (vertex_q.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) $display("unexpected result %p", got);
        end else begin
          want = vertex_q.pop_front();
          if (want.action == ACT_REPLACE) n_replaced = n_replaced + 1;
          if (got !== want) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
    pending = vertex_q.size();
  end

endmodule
`default_nettype wire

// ===== dv/voxel_dedup_capped_point_store_core_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module voxel_dedup_capped_point_store_core_test;
  import vdcps_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int n_results;
  int n_replaced;
  int n_sent;
  int quiet_cycles;

  // stall controls shared between the stimulus and the result sink
  bit idle_on;
  bit long_hold;

  // recent coordinates, reused with jitter to hit held voxels
  logic [31:0] recent_pt[24][3];

  vdcps_in_if  in_ch();
  vdcps_out_if out_ch();

  voxel_dedup_capped_point_store_core dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  vdcps_checker chk (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .pready(pready), .paddr(paddr), .pwdata(pwdata), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending), .n_results(n_results),
    .n_replaced(n_replaced)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drain results; stall in random bursts, or hold off long enough for the
  // block to fill its output register and back up the input channel.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
        long_hold = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // End the run when nothing has moved for far longer than the slowest insert.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("voxel_dedup_capped_point_store_core_test NOT OK");
      $finish;
    end
  end

  // Stop offering, let the checker see the last acceptance, then drain.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Issue one APB write: setup, then access until pready.
  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic setup_store(logic enable, logic [12:0] cap, logic [15:0] vsize);
    wait_drained();
    reg_write(4'd0, {31'd0, enable});
    reg_write(4'd4, {19'd0, cap});
    reg_write(4'd8, {16'd0, vsize});
  endtask

  // Offer one transaction; valid stays high between back-to-back items.
  task automatic send_point(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [7:0] r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.pos_x   <= x;
    in_ch.pos_y   <= y;
    in_ch.pos_z   <= z;
    in_ch.reflect <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  // Mostly revisit or perturb recent voxels; the rest is raw noise,
  // coordinate extremes and the odd clear.
  task automatic send_random();
    int          pick;
    int          j;
    logic [31:0] c[3];
    pick = $urandom_range(0, 99);
    j = $urandom_range(0, 23);
    for (int a = 0; a < 3; a++) begin
      if (pick < 70) c[a] = recent_pt[j][a] + $urandom_range(0, 3);
      else if (pick < 92) c[a] = $urandom;
      else c[a] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    if (pick >= 70 && pick < 92) recent_pt[j] = c;
    send_point(pick >= 97, c[0], c[1], c[2], 8'($urandom));
  endtask

  task automatic run_phase(logic enable, logic [12:0] cap, logic [15:0] vsize, int n);
    setup_store(enable, cap, vsize);
    for (int i = 0; i < n; i++) send_random();
  endtask

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.op      = 1'b0;
    in_ch.pos_x   = '0;
    in_ch.pos_y   = '0;
    in_ch.pos_z   = '0;
    in_ch.reflect = '0;
    idle_on       = 1;
    long_hold     = 0;
    n_sent        = 0;
    for (int j = 0; j < 24; j++)
      for (int a = 0; a < 3; a++) recent_pt[j][a] = $urandom_range(0, 2000) - 1000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset defaults, voxel boundaries, negative floor, extremes, clear.
    send_point(1'b0, 32'd0, 32'd0, 32'd0, 8'd0);
    send_point(1'b0, 32'd99, 32'd50, 32'd1, 8'd255);
    send_point(1'b0, 32'd100, 32'd0, 32'd0, 8'd128);
    send_point(1'b0, -32'sd1, -32'sd1, -32'sd1, 8'd1);
    send_point(1'b0, -32'sd100, -32'sd100, -32'sd100, 8'd254);
    send_point(1'b0, -32'sd101, -32'sd100, -32'sd100, 8'd7);
    send_point(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'hAA);
    send_point(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h55);
    send_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 8'hFF);
    send_point(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_point(1'b0, 32'd0, 32'd0, 32'd0, 8'd0);
    send_point(1'b0, 32'd0, 32'd0, 32'd0, 8'd0);

    // Disabled store ignores inserts, but a clear still acts.
    setup_store(1'b0, 13'd2, 16'd1);
    send_point(1'b0, 32'd5, 32'd5, 32'd5, 8'd9);
    send_point(1'b1, 32'd5, 32'd5, 32'd5, 8'd9);
    // Zero capacity: every new voxel is counted but has no slot.
    setup_store(1'b1, 13'd0, 16'd1);
    send_point(1'b0, 32'd1, 32'd2, 32'd3, 8'd4);
    send_point(1'b0, 32'd1, 32'd2, 32'd3, 8'd4);
    // Single slot: the second distinct voxel goes through the replacement draw.
    setup_store(1'b1, 13'd1, 16'd65535);
    send_point(1'b0, 32'd0, 32'd0, 32'd0, 8'd10);
    send_point(1'b0, 32'd65535, 32'd0, 32'd0, 8'd20);
    send_point(1'b0, -32'sd1, 32'd0, 32'd0, 8'd30);
    // Rewriting an equal value and writing past the registers leave the store alone.
    wait_drained();
    reg_write(4'd8, 32'd65535);
    reg_write(4'd12, $urandom);
    send_point(1'b0, 32'd0, 32'd0, 32'd0, 8'd40);

    // Random phases across the register extremes.
    run_phase(1'b1, 13'd4, 16'd1, 150);
    run_phase(1'b1, 13'd1, 16'd65535, 100);
    run_phase(1'b1, 13'd0, 16'd7, 60);
    run_phase(1'b0, 13'd3, 16'd50, 40);

    // Hold off the sink while the sender keeps offering items.
    setup_store(1'b1, 13'd16, 16'd1000);
    long_hold = 1;
    for (int i = 0; i < 120; i++) send_random();
    // Pause the sender until every result is back, then resume.
    wait_drained();
    for (int i = 0; i < 130; i++) send_random();

    run_phase(1'b1, 13'h1FFF, 16'd3, 150);
    run_phase(1'b1, 13'd8, 16'd0, 150);
    run_phase(1'b1, 13'd2, 16'd100, 200);

    // Last stretch back-to-back with default-sized store.
    idle_on = 0;
    run_phase(1'b1, 13'd4096, 16'd100, 150);
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (400) @(posedge clk);
    $display("sent %0d points over store sizes 0..4096 and voxel sizes 0..65535", n_sent);
    $display("checked %0d results, %0d reservoir replacements", n_results, n_replaced);
    if (fail_count == 0) begin
      $display("voxel_dedup_capped_point_store_core_test OK");
    end else begin
      $display("voxel_dedup_capped_point_store_core_test NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
